// ===== rtl/fdpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpc_pkg
// Shared types and constants of the fractional divider parameter calculator.
// ----------------------------------------------------------------------------
package fdpc_pkg;

    // register widths and reset values
    localparam int VCO_W   = 30;
    localparam int OFS_W   = 16;
    localparam int TGT_W   = 28;
    localparam logic [VCO_W-1:0] VCO_RESET = 30'd890979738;
    localparam logic [OFS_W-1:0] OFS_RESET = 16'd608;

    // register indexes (paddr[2])
    localparam logic REG_VCO = 1'b0;
    localparam logic REG_CW  = 1'b1;

    // datapath widths
    localparam int DIV_W  = 31;          // largest divisor: (2^28-1 + 2^16-1) * 4
    localparam int WORD_W = 32;          // dividend / quotient shift word
    localparam int FRAC_W = 20;
    localparam int P1_W   = 18;
    localparam int P2_W   = 20;
    localparam int Q_W    = 7;

    // fraction denominator, also P3
    localparam logic [FRAC_W-1:0] FRAC_DEN = 20'd1048575;
    localparam logic [P1_W-1:0]   P1_BIAS  = 18'd512;

    // number of cells in each part of the chain
    localparam int A_STEPS = VCO_W;      // integer quotient bits
    localparam int B_STEPS = FRAC_W;     // fraction numerator bits
    localparam int Q_STEPS = Q_W;        // split of 128*b by the denominator
    localparam int N_CELLS = A_STEPS + B_STEPS + Q_STEPS;

    // byte positions within the parameter block
    localparam logic [2:0] BYTE_P3_HI  = 3'd0;
    localparam logic [2:0] BYTE_P3_LO  = 3'd1;
    localparam logic [2:0] BYTE_P1_TOP = 3'd2;
    localparam logic [2:0] BYTE_P1_MID = 3'd3;
    localparam logic [2:0] BYTE_P1_LO  = 3'd4;
    localparam logic [2:0] BYTE_P3P2   = 3'd5;
    localparam logic [2:0] BYTE_P2_MID = 3'd6;
    localparam logic [2:0] BYTE_P2_LO  = 3'd7;

    // data handed from cell to cell
    typedef struct packed {
        logic              synth;        // 1 transmit, 0 receive
        logic [DIV_W-1:0]  div;          // divisor of this phase
        logic [DIV_W-1:0]  rem;          // partial remainder, below div
        logic [WORD_W-1:0] word;         // dividend bits out at top, quotient in at bottom
        logic [VCO_W-1:0]  keep;         // integer quotient kept for the end
    } t_lane;

endpackage

// ===== rtl/fdpc_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpc_div_cell
// One restoring division step: shifts one dividend bit into the remainder,
// subtracts the divisor when it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module fdpc_div_cell
    import fdpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane
);

    logic              r_valid;
    t_lane             r_lane;
    t_lane             n_lane;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              fits;

    // trial subtract
    always_comb begin
        trial = {i_lane.rem, i_lane.word[WORD_W-1]};
        diff  = trial - {1'b0, i_lane.div};
        fits  = (trial >= {1'b0, i_lane.div});
        n_lane      = i_lane;
        n_lane.rem  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        n_lane.word = {i_lane.word[WORD_W-2:0], fits};
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// ===== rtl/fdpc_frac_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpc_frac_prep
// Sets up the fraction division: saves the integer quotient and loads
// remainder * denominator as the next dividend.
// ----------------------------------------------------------------------------
module fdpc_frac_prep
    import fdpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane
);

    localparam int N_W = DIV_W + FRAC_W;

    logic           r_valid;
    t_lane          r_lane;
    t_lane          n_lane;
    logic [N_W-1:0] prod;

    // remainder times the denominator, a constant multiply
    always_comb begin
        prod = {{FRAC_W{1'b0}}, i_lane.rem} * {{DIV_W{1'b0}}, FRAC_DEN};
        n_lane      = i_lane;
        n_lane.keep = i_lane.word[VCO_W-1:0];
        n_lane.rem  = prod[N_W-1:FRAC_W];
        n_lane.word = {prod[FRAC_W-1:0], {(WORD_W-FRAC_W){1'b0}}};
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// ===== rtl/fdpc_byte_ser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpc_byte_ser
// Forms P1 and holds P1/P2, then sends the eight packed register bytes.
// ----------------------------------------------------------------------------
module fdpc_byte_ser
    import fdpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_synth,
    input  logic [VCO_W-1:0]  i_a,
    input  logic [Q_W-1:0]    i_q,
    input  logic [P2_W-1:0]   i_p2,
    output logic              o_take,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_synth_index,
    output logic [2:0]        o_byte_offset,
    output logic [7:0]        o_reg_byte,
    output logic              o_last_byte
);

    logic              r_busy;
    logic [2:0]        r_cnt;
    logic              r_synth;
    logic [P1_W-1:0]   r_p1;
    logic [P2_W-1:0]   r_p2;
    logic              n_busy;
    logic [2:0]        n_cnt;
    logic [P1_W-1:0]   n_p1;
    logic              out_done;
    logic              load;

    // slot is free when empty or when the last byte leaves now
    assign out_done = r_busy && !i_stall && (r_cnt == BYTE_P2_LO);
    assign o_take   = !r_busy || out_done;
    assign load     = i_valid && o_take;

    // P1 = 128*a + q - 512, modulo 2^18
    assign n_p1 = {i_a[P1_W-8:0], {Q_W{1'b0}}} + {{(P1_W-Q_W){1'b0}}, i_q} - P1_BIAS;

    // byte counter
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (r_busy && !i_stall) begin
            n_cnt = r_cnt + 3'd1;
        end
        if (load) begin
            n_busy = 1'b1;
            n_cnt  = BYTE_P3_HI;
        end else if (out_done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= BYTE_P3_HI;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // parameter hold
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_synth <= i_synth;
            r_p1    <= n_p1;
            r_p2    <= i_p2;
        end
    end

    // byte packing
    always_comb begin
        unique case (r_cnt)
            BYTE_P3_HI:  o_reg_byte = FRAC_DEN[15:8];
            BYTE_P3_LO:  o_reg_byte = FRAC_DEN[7:0];
            BYTE_P1_TOP: o_reg_byte = {6'b0, r_p1[17:16]};
            BYTE_P1_MID: o_reg_byte = r_p1[15:8];
            BYTE_P1_LO:  o_reg_byte = r_p1[7:0];
            BYTE_P3P2:   o_reg_byte = {FRAC_DEN[19:16], r_p2[19:16]};
            BYTE_P2_MID: o_reg_byte = r_p2[15:8];
            BYTE_P2_LO:  o_reg_byte = r_p2[7:0];
            default:     o_reg_byte = 8'h00;
        endcase
    end

    assign o_valid       = r_busy;
    assign o_synth_index = r_synth;
    assign o_byte_offset = r_cnt;
    assign o_last_byte   = (r_cnt == BYTE_P2_LO);

endmodule

// ===== rtl/fractional_divider_param_calc_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_divider_param_calc_top
// Divider parameter calculator: a chain of restoring division cells finds
// a = vco / f, b = rem * (2^20 - 1) / f and the P1/P2 split, then 8 bytes out.
// ----------------------------------------------------------------------------
// stages from an accepted transaction to its first byte:
//   (input stage, 30 integer cells, fraction setup, 20 fraction cells, 7 split cells)
// requests: the byte stage takes the next request as the current one's last byte leaves;
//   the cell chain itself takes a new request every cycle unless the byte stage holds it back
// reset: synchronous active low; clears all valid flags and loads the
//   vco and offset registers with their defaults
module fractional_divider_param_calc_top
    import fdpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // request channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_operation,
    input  logic [TGT_W-1:0]  i_target_hz,
    input  logic              i_cw_mode,
    // byte channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_synth_index,
    output logic [2:0]        o_byte_offset,
    output logic [7:0]        o_reg_byte,
    output logic              o_last_byte
);

    logic [VCO_W-1:0] r_vco;
    logic [OFS_W-1:0] r_ofs;
    logic             cfg_wr;

    logic             r_in_valid;
    t_lane            r_in_lane;
    t_lane            n_in_lane;
    logic [TGT_W:0]   sum_hz;
    logic [DIV_W-1:0] freq;
    logic             freq_zero;

    logic             adv;
    logic             take;
    logic             prep_valid;
    t_lane            prep_lane;
    t_lane            q_head;

    logic             cell_valid [N_CELLS];
    t_lane            cell_lane  [N_CELLS];

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vco <= VCO_RESET;
            r_ofs <= OFS_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_VCO) begin
                r_vco <= pwdata[VCO_W-1:0];
            end else begin
                r_ofs <= pwdata[OFS_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_CW) ? {{(32-OFS_W){1'b0}}, r_ofs}
                                         : {{(32-VCO_W){1'b0}}, r_vco};

    // chain moves unless the byte stage is full and blocked
    assign adv     = !cell_valid[N_CELLS-1] || take;
    assign o_stall = !adv;

    // divisor from the request; a zero divisor becomes 1 over a zero dividend
    always_comb begin
        sum_hz    = {1'b0, i_target_hz}
                  + {{(TGT_W+1-OFS_W){1'b0}}, (i_cw_mode ? r_ofs : {OFS_W{1'b0}})};
        freq      = i_operation ? {sum_hz, 2'b00}
                                : {{(DIV_W-TGT_W){1'b0}}, i_target_hz};
        freq_zero = (freq == '0);
        n_in_lane.synth = !i_operation;
        n_in_lane.div   = freq_zero ? {{(DIV_W-1){1'b0}}, 1'b1} : freq;
        n_in_lane.rem   = '0;
        n_in_lane.word  = {(freq_zero ? {VCO_W{1'b0}} : r_vco), {(WORD_W-VCO_W){1'b0}}};
        n_in_lane.keep  = '0;
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in_lane <= n_in_lane;
        end
    end

    // fraction setup between the integer and fraction cells
    fdpc_frac_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (cell_valid[A_STEPS-1]),
        .i_lane  (cell_lane[A_STEPS-1]),
        .o_valid (prep_valid),
        .o_lane  (prep_lane)
    );

    // split of 128*b by the denominator: remainder b, seven zero bits shifted in
    always_comb begin
        q_head       = cell_lane[A_STEPS+B_STEPS-1];
        q_head.rem   = {{(DIV_W-FRAC_W){1'b0}},
                        cell_lane[A_STEPS+B_STEPS-1].word[FRAC_W-1:0]};
        q_head.div   = {{(DIV_W-FRAC_W){1'b0}}, FRAC_DEN};
        q_head.word  = '0;
    end

    // division cell chain
    generate
        for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
            logic  in_valid;
            t_lane in_lane;

            if (g == 0) begin : g_head
                assign in_valid = r_in_valid;
                assign in_lane  = r_in_lane;
            end else if (g == A_STEPS) begin : g_frac
                assign in_valid = prep_valid;
                assign in_lane  = prep_lane;
            end else if (g == A_STEPS + B_STEPS) begin : g_split
                assign in_valid = cell_valid[g-1];
                assign in_lane  = q_head;
            end else begin : g_link
                assign in_valid = cell_valid[g-1];
                assign in_lane  = cell_lane[g-1];
            end

            fdpc_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_valid (in_valid),
                .i_lane  (in_lane),
                .o_valid (cell_valid[g]),
                .o_lane  (cell_lane[g])
            );
        end
    endgenerate

    // byte output stage
    fdpc_byte_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (cell_valid[N_CELLS-1]),
        .i_synth       (cell_lane[N_CELLS-1].synth),
        .i_a           (cell_lane[N_CELLS-1].keep),
        .i_q           (cell_lane[N_CELLS-1].word[Q_W-1:0]),
        .i_p2          (cell_lane[N_CELLS-1].rem[P2_W-1:0]),
        .o_take        (take),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_synth_index (o_synth_index),
        .o_byte_offset (o_byte_offset),
        .o_reg_byte    (o_reg_byte),
        .o_last_byte   (o_last_byte)
    );

endmodule

// ===== sim/fractional_divider_param_calc_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_divider_param_calc_top_test
// Self-checking bench for the divider parameter calculator. A directed table
// of retune requests (zero divisor, extreme targets, small and large
// quotients) is followed by random requests under several vco and offset
// settings. Every accepted request but the typed zero-divisor rows is run
// through a local integer model of the a/b/P1/P2/P3 computation. The eight
// bytes that come out are compared field by field with the expected bytes.
// ----------------------------------------------------------------------------
module fractional_divider_param_calc_top_test;
    import fdpc_pkg::*;

    // request operation codes
    localparam logic OP_TX = 1'b0;
    localparam logic OP_RX = 1'b1;
    // multisynth block written by each path
    localparam logic SYNTH_RX = 1'b0;
    localparam logic SYNTH_TX = 1'b1;

    localparam int RANDOM_PER_PHASE = 60;
    localparam int NUM_DIRECTED     = 21;
    localparam int DRAIN_CYCLES     = 80;
    localparam int CYCLE_LIMIT      = 400000;
    localparam logic [TGT_W-1:0] TGT_MAX = '1;

    typedef logic [7:0][7:0] t_param_bytes;

    // zero divisor: a = b = 0, so P1 = 2^18 - 512, P2 = 0, P3 = 0xFFFFF
    localparam t_param_bytes ZERO_DIV_BYTES =
        {8'h00, 8'h00, 8'hF0, 8'h00, 8'hFE, 8'h03, 8'hFF, 8'hFF};

    typedef struct {
        logic              op;
        logic [TGT_W-1:0]  tgt;
        logic              cw;
        bit                typed;
        t_param_bytes      bytes;
    } t_retune_row;

    typedef struct packed {
        logic       synth;
        logic [2:0] offset;
        logic [7:0] data;
        logic       last;
    } t_param_byte;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [2:0]        paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    logic              i_operation = 1'b0;
    logic [TGT_W-1:0]  i_target_hz = '0;
    logic              i_cw_mode   = 1'b0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    logic              o_synth_index;
    logic [2:0]        o_byte_offset;
    logic [7:0]        o_reg_byte;
    logic              o_last_byte;

    fractional_divider_param_calc_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_target_hz   (i_target_hz),
        .i_cw_mode     (i_cw_mode),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_synth_index (o_synth_index),
        .o_byte_offset (o_byte_offset),
        .o_reg_byte    (o_reg_byte),
        .o_last_byte   (o_last_byte)
    );

    // local copy of the two registers
    logic [VCO_W-1:0] vco_shadow = VCO_RESET;
    logic [OFS_W-1:0] ofs_shadow = OFS_RESET;

    t_param_byte pending_bytes[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int          stall_left = 0;
    t_retune_row directed_rows[NUM_DIRECTED];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // integer form of a, b and the P1/P2/P3 packing
    function automatic t_param_bytes calc_divider_bytes(input logic op,
                                                        input logic [TGT_W-1:0] tgt,
                                                        input logic cw);
        longint unsigned den;
        longint unsigned freq;
        longint unsigned a;
        longint unsigned b;
        longint unsigned rem;
        longint unsigned q;
        longint unsigned p1_full;
        longint unsigned p2_full;
        logic [P1_W-1:0] p1;
        logic [P2_W-1:0] p2;
        logic [FRAC_W-1:0] p3;
        t_param_bytes bytes;
        den = 64'(FRAC_DEN);
        freq = 64'(tgt);
        if (op == OP_RX) begin
            if (cw) freq = freq + 64'(ofs_shadow);
            freq = freq << 2;
        end
        a   = 64'd0;
        b   = 64'd0;
        rem = 64'd0;
        if (freq != 64'd0) begin
            a   = 64'(vco_shadow) / freq;
            rem = 64'(vco_shadow) % freq;
            b   = (rem * den) / freq;
        end
        q       = (64'd128 * b) / den;
        p1_full = 64'd128 * a + q - 64'd512;
        p2_full = 64'd128 * b - den * q;
        p1 = p1_full[P1_W-1:0];
        p2 = p2_full[P2_W-1:0];
        p3 = FRAC_DEN;
        bytes[BYTE_P3_HI]  = p3[15:8];
        bytes[BYTE_P3_LO]  = p3[7:0];
        bytes[BYTE_P1_TOP] = {6'd0, p1[17:16]};
        bytes[BYTE_P1_MID] = p1[15:8];
        bytes[BYTE_P1_LO]  = p1[7:0];
        bytes[BYTE_P3P2]   = {p3[19:16], p2[19:16]};
        bytes[BYTE_P2_MID] = p2[15:8];
        bytes[BYTE_P2_LO]  = p2[7:0];
        return bytes;
    endfunction

    // one request transaction, then queue its eight bytes
    task automatic send_retune(input logic op, input logic [TGT_W-1:0] tgt,
                               input logic cw, input bit typed,
                               input t_param_bytes typed_bytes);
        int gap;
        t_param_bytes bytes;
        t_param_byte entry;
        if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_target_hz <= tgt;
        i_cw_mode   <= cw;
        do @(posedge i_clk); while (o_stall);
        bytes = typed ? typed_bytes : calc_divider_bytes(op, tgt, cw);
        for (int k = 0; k < 8; k++) begin
            entry.synth  = (op == OP_RX) ? SYNTH_RX : SYNTH_TX;
            entry.offset = k[2:0];
            entry.data   = bytes[k];
            entry.last   = (k == 7);
            pending_bytes.push_back(entry);
        end
    endtask

    // random request, weighted toward the target corners
    task automatic send_random_retune();
        logic [TGT_W-1:0] tgt;
        case ($urandom_range(0, 9))
            0:       tgt = '0;
            1:       tgt = TGT_W'(1);
            2:       tgt = TGT_MAX;
            3, 4:    tgt = TGT_W'($urandom());
            5:       tgt = TGT_W'($urandom_range(1, 1000));
            default: tgt = TGT_W'($urandom_range(1, 200000000));
        endcase
        send_retune(1'($urandom_range(0, 1)), tgt, 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    // apb write: setup cycle, access cycle until pready, then back to idle
    task automatic write_register(input logic index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (index == REG_VCO) vco_shadow = value[VCO_W-1:0];
        else                  ofs_shadow = value[OFS_W-1:0];
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // byte receiver: random stall stretch after each accepted byte
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= (stall_left != 1);
        end else if (o_valid && !i_stall) begin
            if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
            n = rx_calm ? 0 : $urandom_range(0, 16);
            stall_left <= n;
            i_stall    <= (n != 0);
        end
    end

    // byte checker
    always @(posedge i_clk) begin
        t_param_byte want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte offset %0d data %02h",
                                          o_byte_offset, o_reg_byte));
            end else begin
                want = pending_bytes.pop_front();
                if (o_synth_index !== want.synth)
                    report_mismatch($sformatf("synth_index %b want %b",
                                              o_synth_index, want.synth));
                if (o_byte_offset !== want.offset)
                    report_mismatch($sformatf("byte_offset %0d want %0d",
                                              o_byte_offset, want.offset));
                if (o_reg_byte !== want.data)
                    report_mismatch($sformatf("reg_byte %02h want %02h at offset %0d",
                                              o_reg_byte, want.data, want.offset));
                if (o_last_byte !== want.last)
                    report_mismatch($sformatf("last_byte %b want %b",
                                              o_last_byte, want.last));
            end
        end
    end

    // stimulus
    initial begin
        directed_rows = '{
            // zero divisor on both paths, cw ignored on transmit
            '{OP_TX, 28'd0,         1'b0, 1'b1, ZERO_DIV_BYTES},
            '{OP_TX, 28'd0,         1'b1, 1'b1, ZERO_DIV_BYTES},
            '{OP_RX, 28'd0,         1'b0, 1'b1, ZERO_DIV_BYTES},
            // offset alone keeps the divisor nonzero
            '{OP_RX, 28'd0,         1'b1, 1'b0, '0},
            // large quotient, P1 keeps its low 18 bits
            '{OP_TX, 28'd1,         1'b0, 1'b0, '0},
            '{OP_TX, 28'd2,         1'b0, 1'b0, '0},
            '{OP_RX, 28'd1,         1'b0, 1'b0, '0},
            '{OP_RX, 28'd1,         1'b1, 1'b0, '0},
            // small quotient, P1 wraps where a is below 4
            '{OP_TX, TGT_MAX,       1'b0, 1'b0, '0},
            '{OP_RX, TGT_MAX,       1'b1, 1'b0, '0},
            '{OP_RX, TGT_MAX,       1'b0, 1'b0, '0},
            '{OP_RX, 28'd222744934, 1'b0, 1'b0, '0},
            '{OP_RX, 28'd222744935, 1'b0, 1'b0, '0},
            '{OP_TX, 28'd200000000, 1'b1, 1'b0, '0},
            // exact division, zero remainder, then assorted targets
            '{OP_TX, 28'd148496623, 1'b0, 1'b0, '0},
            '{OP_TX, 28'd7000000,   1'b0, 1'b0, '0},
            '{OP_RX, 28'd7000000,   1'b1, 1'b0, '0},
            '{OP_RX, 28'd14074000,  1'b0, 1'b0, '0},
            '{OP_TX, 28'h5555555,   1'b1, 1'b0, '0},
            '{OP_RX, 28'hAAAAAAA,   1'b0, 1'b0, '0},
            '{OP_RX, 28'd50,        1'b1, 1'b0, '0}
        };

        // reset
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values
        foreach (directed_rows[r])
            send_retune(directed_rows[r].op, directed_rows[r].tgt, directed_rows[r].cw,
                        directed_rows[r].typed, directed_rows[r].bytes);
        repeat (RANDOM_PER_PHASE) send_random_retune();

        // further register settings, extremes first
        for (int ph = 1; ph <= 4; ph++) begin
            wait_drained();
            case (ph)
                1: begin
                    write_register(REG_VCO, 32'd1);
                    write_register(REG_CW, 32'd0);
                end
                2: begin
                    write_register(REG_VCO, 32'h3FFF_FFFF);
                    write_register(REG_CW, 32'h0000_FFFF);
                end
                3: begin
                    write_register(REG_VCO, $urandom_range(1, 32'h3FFF_FFFF));
                    write_register(REG_CW, $urandom_range(0, 16'hFFFF));
                end
                default: begin
                    write_register(REG_VCO, $urandom_range(800000000, 1000000000));
                    write_register(REG_CW, $urandom_range(300, 1000));
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_retune();
        end

        wait_drained();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
